### src/gmsd_pkg.sv
// ----------------------------------------------------------------------------
// gmsd_pkg: shared types and constants
// Field widths, grid limits and the front-to-back command record.
// ----------------------------------------------------------------------------
package gmsd_pkg;

  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 16;
  localparam int ROW_W       = 4;
  localparam int COL_W       = 4;
  localparam int TYPE_W      = 4;
  localparam int DIST_W      = 5;
  localparam int CNT_W       = 5;
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int DEPTH       = MAX_ROWS * MAX_COLS;
  localparam int NUM_SRC     = 4;

  localparam logic [DIST_W-1:0] NONE_CODE = 5'd31;
  localparam logic [DIST_W-1:0] DIST_CAP  = 5'd30;
  localparam logic [TYPE_W-1:0] FIRST_SRC = 4'd5;

  localparam logic       MODE_WRITE = 1'b0;
  localparam logic       MODE_QUERY = 1'b1;
  localparam logic [0:0] REG_ROWS   = 1'b0;
  localparam logic [0:0] REG_COLS   = 1'b1;

  typedef struct packed {
    logic              query;
    logic              outside;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [TYPE_W-1:0] cell_type;
  } cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_transport;
    logic [DIST_W-1:0] dist_public;
    logic [DIST_W-1:0] dist_landscape;
    logic [DIST_W-1:0] dist_road;
    logic              status;
  } res_t;

endpackage

### src/gmsd_if.sv
// ----------------------------------------------------------------------------
// gmsd channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface gmsd_in_if import gmsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [TYPE_W-1:0] cell_type;
  modport source (output valid, mode, row, col, cell_type, input ready);
  modport sink   (input valid, mode, row, col, cell_type, output ready);
endinterface

interface gmsd_out_if import gmsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] dist_transport;
  logic [DIST_W-1:0] dist_public;
  logic [DIST_W-1:0] dist_landscape;
  logic [DIST_W-1:0] dist_road;
  logic              status;
  modport source (output valid, dist_transport, dist_public, dist_landscape, dist_road,
                  status, input ready);
  modport sink   (input valid, dist_transport, dist_public, dist_landscape, dist_road,
                  status, output ready);
endinterface

interface gmsd_cfg_if ();
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [4:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/grid_multi_source_distance_map_unit.sv
// ----------------------------------------------------------------------------
// grid_multi_source_distance_map_unit: cell grid with nearest-source lookup
// Stores cell types, answers Manhattan distance to each of four source types.
// ----------------------------------------------------------------------------
//  channel | dir | beat carries
//  in_     | in  | mode, row, col, cell_type
//  out_    | out | dist_transport/public/landscape/road, status
//  cfg_    | in  | index (0 rows_in_use, 1 cols_in_use), data
//
// Writes and out-of-grid queries are handled in the back end without a scan.
// In-grid queries scan the store one cell per cycle through its single read port.
// After reset a clearing pass zeroes all 256 cells of the store; items queue
// (2 deep) but are not executed until it ends. Config always accepted.
// Front and back stall independently across the 2-entry queue.
module grid_multi_source_distance_map_unit import gmsd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  gmsd_in_if.sink   in_ch,
  gmsd_out_if.source out_ch,
  gmsd_cfg_if.sink  cfg_ch
);
  logic             q_valid, q_ready;
  cmd_t             q_cmd;
  res_t             res;
  logic [CNT_W-1:0] rows_w, cols_w;

  assign cfg_ch.ready = 1'b1;

  gmsd_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
    .in_row(in_ch.row), .in_col(in_ch.col), .in_cell_type(in_ch.cell_type),
    .cfg_valid(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
    .q_valid, .q_ready, .q_cmd
  );

  // sizes mirrored for the back end's scan bounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_w <= CNT_W'(12);
      cols_w <= CNT_W'(12);
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_ROWS) rows_w <= cfg_ch.data;
      else                          cols_w <= cfg_ch.data;
    end
  end

  gmsd_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .rows_in_use(rows_w), .cols_in_use(cols_w),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  assign out_ch.dist_transport = res.dist_transport;
  assign out_ch.dist_public    = res.dist_public;
  assign out_ch.dist_landscape = res.dist_landscape;
  assign out_ch.dist_road      = res.dist_road;
  assign out_ch.status         = res.status;
endmodule

### src/gmsd_front.sv
// ----------------------------------------------------------------------------
// gmsd_front: item intake and classification
// Holds the grid size registers, flags out-of-grid items, feeds a 2-deep queue.
// ----------------------------------------------------------------------------
module gmsd_front import gmsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [COL_W-1:0]  in_col,
  input  logic [TYPE_W-1:0] in_cell_type,
  input  logic              cfg_valid,
  input  logic [0:0]        cfg_index,
  input  logic [CNT_W-1:0]  cfg_data,
  output logic              q_valid,
  input  logic              q_ready,
  output cmd_t              q_cmd
);
  logic [CNT_W-1:0] rows_r, cols_r;
  cmd_t             slot_r [2];
  logic [1:0]       cnt_r, cnt_nxt;
  logic             rd_r, wr_r;
  logic             push, pop, in_grid;
  cmd_t             cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CNT_W'(12);
      cols_r <= CNT_W'(12);
    end else if (cfg_valid) begin
      if (cfg_index == REG_ROWS) rows_r <= cfg_data;
      else                       cols_r <= cfg_data;
    end
  end

  // sizes above the maximum clamp; a 4-bit index is below 16 always
  assign in_grid = ({1'b0, in_row} < rows_r) && ({1'b0, in_col} < cols_r);

  always_comb begin
    cmd.query     = (in_mode == MODE_QUERY);
    cmd.outside   = !in_grid;
    cmd.row       = in_row;
    cmd.col       = in_col;
    cmd.cell_type = in_cell_type;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rd_r];
  assign cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= cmd;
  end
endmodule

### src/gmsd_back.sv
// ----------------------------------------------------------------------------
// gmsd_back: cell store and distance scan
// Writes cells, scans the in-use grid one cell a cycle for queries.
// ----------------------------------------------------------------------------
module gmsd_back import gmsd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  cmd_t             q_cmd,
  input  logic [CNT_W-1:0] rows_in_use,
  input  logic [CNT_W-1:0] cols_in_use,
  output logic             out_valid,
  input  logic             out_ready,
  output res_t             out_res
);
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [TYPE_W-1:0] mem [DEPTH];
  logic [TYPE_W-1:0] rd_data_r;
  logic [1:0]        st_r;
  logic [ADDR_W-1:0] clr_r;
  logic [ROW_W-1:0]  sr_r, qr_r, pr_r;
  logic [COL_W-1:0]  sc_r, qc_r, pc_r;
  logic              pv_r, last_r;
  logic [DIST_W-1:0] best_r [NUM_SRC];
  logic              ov_r, ov_nxt;
  res_t              res_r;
  logic [ROW_W-1:0]  lr;
  logic [COL_W-1:0]  lc;
  logic              take, ob_free, we, scan_end;
  logic [ADDR_W-1:0] waddr;
  logic [ROW_W:0]    dr, dc;
  logic [ROW_W+1:0]  dsum;
  logic [DIST_W-1:0] d;
  logic [TYPE_W-1:0] sidx;

  // clamp sizes; zero sizes never reach the scan (query is outside)
  assign lr = (rows_in_use > CNT_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS - 1) : ROW_W'(rows_in_use - 1'b1);
  assign lc = (cols_in_use > CNT_W'(MAX_COLS)) ? COL_W'(MAX_COLS - 1) : COL_W'(cols_in_use - 1'b1);

  assign ob_free  = !ov_r || out_ready;
  assign q_ready  = (st_r == ST_IDLE) && ob_free;
  assign take     = q_valid && q_ready;
  assign we       = (st_r == ST_CLEAR) ||
                    (take && !q_cmd.query && !q_cmd.outside);
  assign waddr    = (st_r == ST_CLEAR) ? clr_r : {q_cmd.row, q_cmd.col};
  assign scan_end = (sr_r == lr) && (sc_r == lc);

  // result register: loads on an outside query or a finished scan, else holds until taken
  assign ov_nxt = (take && q_cmd.query && q_cmd.outside) ||
                  ((st_r == ST_DONE) && ob_free) ||
                  (ov_r && !out_ready);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= (st_r == ST_CLEAR) ? '0 : q_cmd.cell_type;
    rd_data_r <= mem[{sr_r, sc_r}];
  end

  // distance of the cell read last cycle
  assign dr   = (pr_r > qr_r) ? {1'b0, pr_r - qr_r} : {1'b0, qr_r - pr_r};
  assign dc   = (pc_r > qc_r) ? {1'b0, pc_r - qc_r} : {1'b0, qc_r - pc_r};
  assign dsum = {1'b0, dr} + {1'b0, dc};
  assign d    = (dsum > (ROW_W+2)'(DIST_CAP)) ? DIST_CAP : DIST_W'(dsum);
  assign sidx = rd_data_r - FIRST_SRC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      clr_r <= '0;
      pv_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      case (st_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == ADDR_W'(DEPTH - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (take && q_cmd.query) begin
            if (q_cmd.outside) begin
              res_r <= '{default: '0, status: 1'b1};
            end else begin
              st_r   <= ST_SCAN;
              sr_r   <= '0;
              sc_r   <= '0;
              qr_r   <= q_cmd.row;
              qc_r   <= q_cmd.col;
              last_r <= 1'b0;
              for (int k = 0; k < NUM_SRC; k++) best_r[k] <= NONE_CODE;
            end
          end
        end
        ST_SCAN: begin
          pv_r   <= !last_r;
          pr_r   <= sr_r;
          pc_r   <= sc_r;
          if (!last_r) begin
            if (scan_end) last_r <= 1'b1;
            else if (sc_r == lc) begin
              sc_r <= '0;
              sr_r <= sr_r + 1'b1;
            end else sc_r <= sc_r + 1'b1;
          end
          if (pv_r && rd_data_r >= FIRST_SRC && rd_data_r < FIRST_SRC + TYPE_W'(NUM_SRC))
            if (d < best_r[sidx[1:0]]) best_r[sidx[1:0]] <= d;
          if (last_r && !pv_r) st_r <= ST_DONE;
        end
        ST_DONE: begin
          if (ob_free) begin
            res_r <= '{best_r[0], best_r[1], best_r[2], best_r[3], 1'b0};
            st_r  <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_res   = res_r;
endmodule

### src/gmsd_checker.sv
// ----------------------------------------------------------------------------
// gmsd_checker: port-level checks
// Result and config channel behavior seen from the top level's ports.
// ----------------------------------------------------------------------------
module gmsd_checker import gmsd_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DIST_W-1:0] dist_transport,
  input logic             status,
  input logic             cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(dist_transport))
    else $error("result dropped while stalled");
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> dist_transport == '0)
    else $error("outside result carries a distance");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port stalled");
endmodule

bind grid_multi_source_distance_map_unit gmsd_checker u_chk (
  .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .dist_transport(out_ch.dist_transport), .status(out_ch.status),
  .cfg_ready(cfg_ch.ready)
);
